// ===== rtl/core/grp_pkg.sv =====
// shared types and codes for the guillotine rectangle packer
package grp_pkg;

  // bit width of the incoming rectangle's width and height
  localparam int unsigned RectBits = 14;
  // width of every result coordinate
  localparam int unsigned OutBits  = 16;

  // classified operation of one input word
  typedef enum logic [0:0] {
    OP_PLACE = 1'b0,
    OP_CLEAR = 1'b1
  } op_t;

  // classified command between front and back
  typedef struct packed {
    op_t                 op;
    logic [RectBits-1:0] w;
    logic [RectBits-1:0] h;
  } cmd_t;

  // one result word
  typedef struct packed {
    logic [OutBits-1:0] u_start;
    logic [OutBits-1:0] u_end;
    logic [OutBits-1:0] v_start;
    logic [OutBits-1:0] v_end;
    logic [OutBits-1:0] atlas_width_now;
    logic [OutBits-1:0] atlas_height_now;
    logic               from_free_region;
    logic               region_dropped;
    logic               size_overflow;
  } res_t;

endpackage

// ===== rtl/core/grp_fifo.sv =====
// small synchronous word queue
module grp_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LastPtr = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DepthCnt = CW'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == DepthCnt);
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== rtl/core/grp_front.sv =====
// front end: takes input words, classifies them and queues commands
module grp_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               push,
  output logic                               full,
  input  logic                               in_mode,
  input  logic [grp_pkg::RectBits-1:0]       in_rect_width,
  input  logic [grp_pkg::RectBits-1:0]       in_rect_height,
  output logic                               cmd_valid,
  input  logic                               cmd_pop,
  output grp_pkg::cmd_t                      cmd
);

  grp_pkg::cmd_t                    cmd_in;
  logic [$bits(grp_pkg::cmd_t)-1:0] cmd_raw;
  logic                             cmd_empty;

  // classify the word
  always_comb begin
    cmd_in.op = in_mode ? grp_pkg::OP_CLEAR : grp_pkg::OP_PLACE;
    cmd_in.w  = in_rect_width;
    cmd_in.h  = in_rect_height;
  end

  grp_fifo #(
    .WIDTH($bits(grp_pkg::cmd_t)),
    .DEPTH(2)
  ) u_cmd_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (push),
    .wr_data(cmd_in),
    .full   (full),
    .rd_en  (cmd_pop),
    .rd_data(cmd_raw),
    .empty  (cmd_empty)
  );

  assign cmd_valid = !cmd_empty;
  assign cmd       = grp_pkg::cmd_t'(cmd_raw);

endmodule

// ===== rtl/core/grp_back.sv =====
// back end: free region cell chain, first-fit search, compaction and append
module grp_back #(
  parameter int unsigned MAX_FREE_REGIONS = 64,
  parameter int unsigned COORD_BITS       = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  output logic          cmd_pop,
  input  grp_pkg::cmd_t cmd,
  input  logic          res_full,
  output logic          res_push,
  output grp_pkg::res_t res
);

  localparam int unsigned N  = COORD_BITS;
  localparam int unsigned M  = MAX_FREE_REGIONS;
  localparam int unsigned CW = $clog2(M + 1);
  localparam int unsigned SW = CW + 1;
  localparam int unsigned XW = ((N > grp_pkg::OutBits) ? N : grp_pkg::OutBits) + 2;
  localparam int unsigned RB = grp_pkg::RectBits;
  localparam int unsigned OB = grp_pkg::OutBits;
  localparam logic [XW-1:0] CMax   = {{(XW-N){1'b0}}, {N{1'b1}}};
  localparam logic [SW-1:0] MaxSlot = SW'(M);

  typedef struct packed {
    logic [N-1:0] u0;
    logic [N-1:0] u1;
    logic [N-1:0] v0;
    logic [N-1:0] v1;
  } region_t;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_PICK   = 4'b0100,
    S_COMMIT = 4'b1000
  } state_t;

  state_t        state_r, state_nxt;
  grp_pkg::cmd_t cur_r;
  region_t       cells_r [M];
  logic [CW-1:0] count_r, count_nxt;
  logic [N-1:0]  aw_r, aw_nxt;
  logic [N-1:0]  ah_r, ah_nxt;
  logic [M-1:0]  hit_r, hit_nxt;
  logic [M-1:0]  shift_r;
  logic          fit_r;
  region_t       sel_r, sel_nxt;
  logic [M-1:0]  first_hit;

  // commit-side values
  logic [XW-1:0] w_x, h_x, aw_x, ah_x;
  logic [XW-1:0] su0, su1, sv0, sv1;
  logic [XW-1:0] f_ue, f_ve, ra_u0, lb_v0;
  logic [XW-1:0] nh, vs_raw, ve_raw, vs_c, ve_c, ue_raw, ue_c, w2;
  logic          sovf, ue_ovf, grow, wovf;
  logic          va, vb, kept_a, kept_b;
  region_t       ent_a, ent_b;
  logic [CW-1:0] c_base;
  logic [SW-1:0] slot_a, slot_b;
  logic          place;
  logic [XW-1:0] o_us, o_ue, o_vs, o_ve, o_aw;

  // parallel fit compare over the cell chain
  always_comb begin
    for (int i = 0; i < M; i++) begin
      hit_nxt[i] = (CW'(i) < count_r)
        && (({{(XW-N){1'b0}}, cells_r[i].u1} - {{(XW-N){1'b0}}, cells_r[i].u0}
             + XW'(1)) >= {{(XW-RB){1'b0}}, cur_r.w})
        && (({{(XW-N){1'b0}}, cells_r[i].v1} - {{(XW-N){1'b0}}, cells_r[i].v0}
             + XW'(1)) >= {{(XW-RB){1'b0}}, cur_r.h});
    end
  end

  // first hit, its region and the compaction mask
  assign first_hit = hit_r & (~hit_r + M'(1));
  always_comb begin
    sel_nxt = '0;
    for (int i = 0; i < M; i++) begin
      sel_nxt = sel_nxt | (first_hit[i] ? cells_r[i] : '0);
    end
  end

  // placement arithmetic
  always_comb begin
    place = (cur_r.op == grp_pkg::OP_PLACE);
    w_x   = {{(XW-RB){1'b0}}, cur_r.w};
    h_x   = {{(XW-RB){1'b0}}, cur_r.h};
    aw_x  = {{(XW-N){1'b0}}, aw_r};
    ah_x  = {{(XW-N){1'b0}}, ah_r};
    su0   = {{(XW-N){1'b0}}, sel_r.u0};
    su1   = {{(XW-N){1'b0}}, sel_r.u1};
    sv0   = {{(XW-N){1'b0}}, sel_r.v0};
    sv1   = {{(XW-N){1'b0}}, sel_r.v1};
    // fit path
    f_ue  = su0 + w_x - XW'(1);
    f_ve  = sv0 + h_x - XW'(1);
    ra_u0 = su0 + w_x + XW'(1);
    lb_v0 = sv0 + h_x + XW'(1);
    // new strip path
    nh     = ah_x + h_x + XW'(1);
    sovf   = nh > CMax;
    vs_raw = ah_x + XW'(1);
    ve_raw = ah_x + h_x;
    vs_c   = (sovf && (vs_raw > CMax)) ? CMax : vs_raw;
    ve_c   = (sovf && (ve_raw > CMax)) ? CMax : ve_raw;
    ue_raw = w_x + XW'(1);
    ue_ovf = ue_raw > CMax;
    ue_c   = ue_ovf ? CMax : ue_raw;
    // atlas width growth
    w2   = w_x + XW'(2);
    grow = aw_x < w2;
    wovf = grow && (w2 > CMax);
    o_aw = grow ? (wovf ? CMax : w2) : aw_x;

    // regions to append, in order
    if (fit_r) begin
      va       = ra_u0 <= su1;
      ent_a.u0 = ra_u0[N-1:0];
      ent_a.u1 = sel_r.u1;
      ent_a.v0 = sel_r.v0;
      ent_a.v1 = sel_r.v1;
      vb       = (cur_r.w != '0) && (lb_v0 <= sv1);
      ent_b.u0 = sel_r.u0;
      ent_b.u1 = f_ue[N-1:0];
      ent_b.v0 = lb_v0[N-1:0];
      ent_b.v1 = sel_r.v1;
      o_us     = su0;
      o_ue     = f_ue;
      o_vs     = sv0;
      o_ve     = f_ve;
      c_base   = count_r - CW'(1);
    end else begin
      va       = !sovf && (aw_x >= w_x + XW'(4)) && (cur_r.h != '0);
      ent_a.u0 = N'(w_x + XW'(3));
      ent_a.u1 = N'(aw_x - XW'(1));
      ent_a.v0 = vs_c[N-1:0];
      ent_a.v1 = ve_c[N-1:0];
      vb       = 1'b0;
      ent_b    = ent_a;
      o_us     = XW'(2);
      o_ue     = ue_c;
      o_vs     = vs_c;
      o_ve     = ve_c;
      c_base   = count_r;
    end
    va     = va && place;
    vb     = vb && place;
    slot_a = {1'b0, c_base};
    slot_b = {1'b0, c_base} + SW'(va);
    kept_a = va && (slot_a < MaxSlot);
    kept_b = vb && (slot_b < MaxSlot);
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cmd_pop   = 1'b0;
    res_push  = 1'b0;
    count_nxt = count_r;
    aw_nxt    = aw_r;
    ah_nxt    = ah_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid && !res_full) begin
          cmd_pop   = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        state_nxt = S_PICK;
      end
      S_PICK: begin
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        res_push  = 1'b1;
        state_nxt = S_IDLE;
        if (place) begin
          count_nxt = CW'({1'b0, c_base} + SW'(kept_a) + SW'(kept_b));
          aw_nxt    = o_aw[N-1:0];
          if (!fit_r) begin
            ah_nxt = sovf ? CMax[N-1:0] : nh[N-1:0];
          end
        end else begin
          count_nxt = '0;
          aw_nxt    = '0;
          ah_nxt    = N'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result word
  always_comb begin
    if (place) begin
      res.u_start          = o_us[OB-1:0];
      res.u_end            = o_ue[OB-1:0];
      res.v_start          = o_vs[OB-1:0];
      res.v_end            = o_ve[OB-1:0];
      res.atlas_width_now  = o_aw[OB-1:0];
      res.atlas_height_now = fit_r ? ah_x[OB-1:0]
                                   : (sovf ? CMax[OB-1:0] : nh[OB-1:0]);
      res.from_free_region = fit_r;
      res.region_dropped   = (va && !kept_a) || (vb && !kept_b);
      res.size_overflow    = (!fit_r && (sovf || ue_ovf)) || wovf;
    end else begin
      res                  = '0;
      res.atlas_height_now = OB'(1);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      aw_r    <= '0;
      ah_r    <= N'(1);
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      aw_r    <= aw_nxt;
      ah_r    <= ah_nxt;
    end
  end

  // per-item working registers
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur_r <= cmd;
    end
    if (state_r == S_SCAN) begin
      hit_r <= hit_nxt;
    end
    if (state_r == S_PICK) begin
      sel_r   <= sel_nxt;
      fit_r   <= |hit_r;
      shift_r <= ~(first_hit - M'(1));
    end
  end

  // cell chain: shift down over the removed region, then take appends
  for (genvar g = 0; g < M; g++) begin : g_cell
    region_t upper;
    if (g == M - 1) begin : g_top
      assign upper = cells_r[g];
    end else begin : g_mid
      assign upper = cells_r[g+1];
    end
    always_ff @(posedge clk) begin
      if (state_r == S_COMMIT && place) begin
        if (kept_b && slot_b == SW'(g)) begin
          cells_r[g] <= ent_b;
        end else if (kept_a && slot_a == SW'(g)) begin
          cells_r[g] <= ent_a;
        end else if (fit_r && shift_r[g]) begin
          cells_r[g] <= upper;
        end
      end
    end
  end

endmodule

// ===== rtl/core/guillotine_rect_packer.sv =====
// Guillotine rectangle packer: first-fit over a free region cell chain.
// Each accepted word is queued, then fetched, compared, picked and committed by
// the back end over the cell chain before its result enters the result queue;
// a new word is fetched only after commit. Queues decouple both sides.
// Reset (synchronous, rst_n low): queues empty, free list count 0,
// atlas width 0, atlas height 1; list contents are not cleared.
module guillotine_rect_packer #(
  parameter int unsigned MAX_FREE_REGIONS = 64,
  parameter int unsigned COORD_BITS       = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  output logic                            full,
  input  logic                            in_mode,
  input  logic [grp_pkg::RectBits-1:0]    in_rect_width,
  input  logic [grp_pkg::RectBits-1:0]    in_rect_height,
  output logic                            empty,
  input  logic                            pop,
  output logic [grp_pkg::OutBits-1:0]     out_u_start,
  output logic [grp_pkg::OutBits-1:0]     out_u_end,
  output logic [grp_pkg::OutBits-1:0]     out_v_start,
  output logic [grp_pkg::OutBits-1:0]     out_v_end,
  output logic [grp_pkg::OutBits-1:0]     out_atlas_width_now,
  output logic [grp_pkg::OutBits-1:0]     out_atlas_height_now,
  output logic                            out_from_free_region,
  output logic                            out_region_dropped,
  output logic                            out_size_overflow
);

  logic                             cmd_valid, cmd_pop;
  grp_pkg::cmd_t                    cmd;
  logic                             res_full, res_push;
  grp_pkg::res_t                    res_in, res_out;
  logic [$bits(grp_pkg::res_t)-1:0] res_raw;

  grp_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_mode       (in_mode),
    .in_rect_width (in_rect_width),
    .in_rect_height(in_rect_height),
    .cmd_valid     (cmd_valid),
    .cmd_pop       (cmd_pop),
    .cmd           (cmd)
  );

  grp_back #(
    .MAX_FREE_REGIONS(MAX_FREE_REGIONS),
    .COORD_BITS      (COORD_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_valid(cmd_valid),
    .cmd_pop  (cmd_pop),
    .cmd      (cmd),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res_in)
  );

  // result word queue
  grp_fifo #(
    .WIDTH($bits(grp_pkg::res_t)),
    .DEPTH(2)
  ) u_res_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (res_push),
    .wr_data(res_in),
    .full   (res_full),
    .rd_en  (pop),
    .rd_data(res_raw),
    .empty  (empty)
  );

  assign res_out              = grp_pkg::res_t'(res_raw);
  assign out_u_start          = res_out.u_start;
  assign out_u_end            = res_out.u_end;
  assign out_v_start          = res_out.v_start;
  assign out_v_end            = res_out.v_end;
  assign out_atlas_width_now  = res_out.atlas_width_now;
  assign out_atlas_height_now = res_out.atlas_height_now;
  assign out_from_free_region = res_out.from_free_region;
  assign out_region_dropped   = res_out.region_dropped;
  assign out_size_overflow    = res_out.size_overflow;

endmodule

// ===== rtl/core/grp_checker.sv =====
// port-level checks for the rectangle packer, bound to the top level
module grp_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        push,
  input logic                        full,
  input logic                        empty,
  input logic                        pop,
  input logic [grp_pkg::OutBits-1:0] out_u_start,
  input logic [grp_pkg::OutBits-1:0] out_v_start,
  input logic                        out_from_free_region
);

  // both queues come out of reset empty
  a_reset_in: assert property (@(posedge clk) !rst_n |=> !full)
    else $error("input side full after reset");
  a_reset_out: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result word present after reset");

  // a placement inside a free region never starts at column zero
  a_region_col: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_from_free_region) |-> (out_u_start != '0))
    else $error("free region placement at column zero");

  // a stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_u_start) && $stable(out_v_start)))
    else $error("stalled result word changed");

endmodule

bind guillotine_rect_packer grp_checker u_grp_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .push                (push),
  .full                (full),
  .empty               (empty),
  .pop                 (pop),
  .out_u_start         (out_u_start),
  .out_v_start         (out_v_start),
  .out_from_free_region(out_from_free_region)
);
